FILE: rtl/rwsz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsz_pkg: shared types and constants
// Register indexes, statistic codes, output limits and the command/status
// words that pass between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package rwsz_pkg;

	localparam int CNT_W  = 8;
	localparam int SH_W   = CNT_W + 1;
	localparam int VAL_W  = 40;
	localparam int MODE_W = 3;
	localparam int WLEN_W = 9;

	localparam logic REG_WINDOW_LEN = 1'b0;
	localparam logic REG_STAT_MODE  = 1'b1;

	localparam logic [MODE_W-1:0] MODE_SUM  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MEAN = 3'd1;
	localparam logic [MODE_W-1:0] MODE_VAR  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_STD  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_Z    = 3'd4;

	localparam logic [VAL_W-1:0] VAL_MAX = 40'h7F_FFFF_FFFF;
	localparam logic [VAL_W-1:0] VAL_MIN = 40'h80_0000_0000;

	typedef enum logic [1:0] {
		OP_DIV  = 2'b01,
		OP_SQRT = 2'b10
	} iter_op_t;

	typedef struct packed {
		logic             start;
		iter_op_t         op;
		logic [CNT_W-1:0] count;
	} iter_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_stat_t;

endpackage

FILE: rtl/rwsz_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsz channel interfaces
// Valid/ready channels for input samples and for result words.
// ----------------------------------------------------------------------------
interface rwsz_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          first;
	logic                          last;

	modport source (output valid, sample, first, last, input ready);
	modport sink   (input valid, sample, first, last, output ready);
endinterface

interface rwsz_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [rwsz_pkg::VAL_W-1:0]   value;
	logic                                short_error;

	modport source (output valid, value, short_error, input ready);
	modport sink   (input valid, value, short_error, output ready);
endinterface

FILE: rtl/rwsz_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsz_ring: sample ring memory
// One write port and one registered read port; a read of the slot being
// written returns the old word.
// ----------------------------------------------------------------------------
module rwsz_ring #(
	parameter int DEPTH = 256,
	parameter int AWID  = 8,
	parameter int DW    = 16
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AWID-1:0] waddr,
	input  logic [DW-1:0]   wdata,
	input  logic [AWID-1:0] raddr,
	output logic [DW-1:0]   rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/rwsz_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsz_iter: shared divide / square-root unit
// Restoring divide (one quotient bit per cycle) or digit-by-digit square root
// (one root bit per cycle) through one shared compare-and-subtract.
// ----------------------------------------------------------------------------
module rwsz_iter #(
	parameter int NW = 69
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rwsz_pkg::iter_cmd_t  cmd,
	input  logic [NW-1:0]        num,
	input  logic [NW-1:0]        den,
	output rwsz_pkg::iter_stat_t stat,
	output logic [NW-1:0]        res
);

	logic [NW-1:0]                rem_q, acc_q, res_q, den_q;
	rwsz_pkg::iter_op_t           op_q;
	logic [rwsz_pkg::CNT_W-1:0]   cnt_q;
	logic                         busy_q, done_q;
	logic [rwsz_pkg::SH_W-1:0]    sh;
	logic [NW+1:0]                rem_n, sub, diff;
	logic                         ge;
	logic                         take;

	assign take = cmd.start && !busy_q;

	always_comb begin
		if (cmd.op == rwsz_pkg::OP_SQRT) begin
			sh = rwsz_pkg::SH_W'(NW) - {cmd.count, 1'b0};
		end else begin
			sh = rwsz_pkg::SH_W'(NW) - {1'b0, cmd.count};
		end
		if (op_q == rwsz_pkg::OP_SQRT) begin
			rem_n = {rem_q, acc_q[NW-1:NW-2]};
			sub   = {res_q, 2'b01};
		end else begin
			rem_n = {1'b0, rem_q, acc_q[NW-1]};
			sub   = {2'b00, den_q};
		end
		ge   = rem_n >= sub;
		diff = rem_n - sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (take) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rwsz_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q  <= cmd.op;
			den_q <= den;
			res_q <= '0;
			acc_q <= num << sh;
			if (cmd.op == rwsz_pkg::OP_SQRT) begin
				rem_q <= '0;
			end else begin
				rem_q <= num >> cmd.count;
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[NW-1:0] : rem_n[NW-1:0];
			res_q <= {res_q[NW-2:0], ge};
			acc_q <= (op_q == rwsz_pkg::OP_SQRT) ? (acc_q << 2) : (acc_q << 1);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign res       = res_q;

endmodule

FILE: rtl/rolling_window_stats_zscore_top.sv
`timescale 1ns / 1ps
// Sum, unused modes, zero-deviation z and short errors finish without the shared unit;
// mean, variance, deviation and z-score use it: deviation in two passes (root, then
// divide by the window length) and z-score in two (divide, then root).
// A new sample is taken only when idle, in the cycle after the result loads.
// A finished word waits in the output register while the next sample is taken.
// Reset (asynchronous, active low) empties the window, sets window_len 1 and stat_mode 0.
// ----------------------------------------------------------------------------
// rolling_window_stats_zscore_top: sliding-window sum/mean/variance/deviation/z
// Sample ring, running sums, APB registers and the sequencer that drives the
// shared divide / square-root unit.
// ----------------------------------------------------------------------------
module rolling_window_stats_zscore_top #(
	parameter int WINDOW_MAX  = 256,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	rwsz_in_if.sink      in_ch,
	rwsz_out_if.source   out_ch
);

	localparam int S      = SAMPLE_BITS;
	localparam int F      = FRAC_BITS;
	localparam int AW     = $clog2(WINDOW_MAX + 1);
	localparam int SW     = $clog2(WINDOW_MAX);
	localparam int EW     = (AW > rwsz_pkg::WLEN_W) ? AW : rwsz_pkg::WLEN_W;
	localparam int SUM_W  = S + AW;
	localparam int SQ_W   = 2 * S + AW;
	localparam int D_W    = 2 * (S + AW);
	localparam int N_W    = S + AW + 1;
	localparam int NSQ_W  = 2 * N_W;
	localparam int W2_W   = 2 * AW;
	localparam int NW     = 2 * N_W + 2 * F + 1;
	localparam int BIGW   = ((NW > rwsz_pkg::VAL_W) ? NW : rwsz_pkg::VAL_W) + 1;
	localparam int K_MEAN = SUM_W + F;
	localparam int K_VAR  = 2 * S + F;
	localparam int M_STD  = (D_W + 2 * F + 1) / 2;
	localparam int K_STD  = S + F + 1;
	localparam int K_Z    = 2 * F + AW;
	localparam int M_Z    = (K_Z + 1) / 2;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_RD   = 10'b00_0000_0010,
		ST_UPD  = 10'b00_0000_0100,
		ST_SQR  = 10'b00_0000_1000,
		ST_MUL  = 10'b00_0001_0000,
		ST_DIFF = 10'b00_0010_0000,
		ST_NSQ  = 10'b00_0100_0000,
		ST_OP1  = 10'b00_1000_0000,
		ST_RUN  = 10'b01_0000_0000,
		ST_DONE = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [rwsz_pkg::WLEN_W-1:0] window_len_q;
	logic [rwsz_pkg::MODE_W-1:0] stat_mode_q;
	logic                        cfg_wr;
	logic                        cfg_idx;

	// window state
	logic [SW-1:0]           slot_q;
	logic [AW-1:0]           fill_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sumsq_q;
	logic                    full_q;

	// item payload and products
	logic signed [S-1:0]     x_q;
	logic                    first_q, last_q;
	logic [2*S-1:0]          xsq_q, oldsq_q;
	logic [D_W-1:0]          wsq_q, ssq_q, d_q;
	logic [W2_W-1:0]         w2_q;
	logic signed [N_W-1:0]   wx_q, n_q;
	logic [NSQ_W-1:0]        nsq_q;
	logic                    second_q;

	// result staging
	logic [NW-1:0]           mag_q;
	logic                    neg_q, err_q, has_q;
	logic                    out_valid_q;
	logic [rwsz_pkg::VAL_W-1:0] out_value_q;
	logic                    out_err_q;

	// combinational
	logic [AW-1:0]           w;
	logic [EW-1:0]           wl_ext;
	logic [SW-1:0]           slot_e, slot_nx, raddr;
	logic [AW-1:0]           fill_e;
	logic                    full_e;
	logic [SW+1:0]           old_a;
	logic signed [S-1:0]     old_s;
	logic signed [2*S-1:0]   xsq_full, oldsq_full;
	logic [SUM_W-1:0]        sum_mag;
	logic [N_W-1:0]          n_mag;
	logic signed [N_W-1:0]   w_s, x_s;
	logic                    has_out;

	rwsz_pkg::iter_cmd_t     cmd;
	rwsz_pkg::iter_stat_t    ist;
	logic [NW-1:0]           it_num, it_den, it_res;

	logic                    set_res;
	logic [NW-1:0]           set_mag;
	logic                    set_neg, set_err, set_has;
	logic                    go_second;

	logic                    load_out;
	logic [BIGW-1:0]         mag_ext;
	logic [rwsz_pkg::VAL_W-1:0] val_sat;

	// ---------------- APB ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = (cfg_idx == rwsz_pkg::REG_WINDOW_LEN) ? 32'(window_len_q)
	                                                       : 32'(stat_mode_q);

	// ---------------- window arithmetic ----------------
	always_comb begin
		wl_ext = EW'(window_len_q);
		if (wl_ext == '0) begin
			w = AW'(1);
		end else if (wl_ext > EW'(WINDOW_MAX)) begin
			w = AW'(WINDOW_MAX);
		end else begin
			w = wl_ext[AW-1:0];
		end

		slot_e = first_q ? '0 : slot_q;
		fill_e = first_q ? '0 : fill_q;
		full_e = fill_e >= w;

		old_a = (SW+2)'(slot_e) + (SW+2)'(WINDOW_MAX) - (SW+2)'(w);
		if (old_a >= (SW+2)'(WINDOW_MAX)) begin
			old_a = old_a - (SW+2)'(WINDOW_MAX);
		end
		raddr   = old_a[SW-1:0];
		slot_nx = (slot_e == SW'(WINDOW_MAX - 1)) ? '0 : slot_e + 1'b1;

		xsq_full   = (2*S)'(x_q) * (2*S)'(x_q);
		oldsq_full = (2*S)'(old_s) * (2*S)'(old_s);

		sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		n_mag   = n_q[N_W-1] ? N_W'(-n_q) : N_W'(n_q);
		w_s     = N_W'($signed({1'b0, w}));
		x_s     = N_W'(x_q);
		has_out = fill_q >= w;
	end

	rwsz_ring #(
		.DEPTH (WINDOW_MAX),
		.AWID  (SW),
		.DW    (S)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_RD),
		.waddr (slot_e),
		.wdata (x_q),
		.raddr (raddr),
		.rdata (old_s)
	);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.op    = rwsz_pkg::OP_DIV;
		it_num    = '0;
		it_den    = '0;
		set_res   = 1'b0;
		set_mag   = '0;
		set_neg   = 1'b0;
		set_err   = 1'b0;
		set_has   = 1'b1;
		go_second = 1'b0;
		load_out  = 1'b0;

		unique case (state_q)
			ST_IDLE: if (in_ch.valid) state_d = ST_RD;
			ST_RD:   state_d = ST_UPD;
			ST_UPD:  state_d = ST_SQR;
			ST_SQR:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_DIFF;
			ST_DIFF: state_d = ST_NSQ;
			ST_NSQ:  state_d = ST_OP1;
			ST_OP1: begin
				state_d = ST_DONE;
				set_res = 1'b1;
				if (!has_out) begin
					set_err = last_q;
					set_has = last_q;
				end else begin
					unique case (stat_mode_q)
						rwsz_pkg::MODE_SUM: begin
							set_mag = NW'(sum_mag);
							set_neg = sum_q[SUM_W-1];
						end
						rwsz_pkg::MODE_MEAN: begin
							set_res   = 1'b0;
							state_d   = ST_RUN;
							cmd.start = 1'b1;
							cmd.count = rwsz_pkg::CNT_W'(K_MEAN);
							it_num    = NW'(sum_mag) << F;
							it_den    = NW'(w);
						end
						rwsz_pkg::MODE_VAR: begin
							set_res   = 1'b0;
							state_d   = ST_RUN;
							cmd.start = 1'b1;
							cmd.count = rwsz_pkg::CNT_W'(K_VAR);
							it_num    = NW'(d_q) << F;
							it_den    = NW'(w2_q);
						end
						rwsz_pkg::MODE_STD: begin
							set_res   = 1'b0;
							state_d   = ST_RUN;
							cmd.start = 1'b1;
							cmd.op    = rwsz_pkg::OP_SQRT;
							cmd.count = rwsz_pkg::CNT_W'(M_STD);
							it_num    = NW'(d_q) << (2 * F);
						end
						rwsz_pkg::MODE_Z: begin
							// zero deviation gives zero
							if (d_q != '0) begin
								set_res   = 1'b0;
								state_d   = ST_RUN;
								cmd.start = 1'b1;
								cmd.count = rwsz_pkg::CNT_W'(K_Z);
								it_num    = NW'(nsq_q) << (2 * F);
								it_den    = NW'(d_q);
							end
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				if (ist.done) begin
					if (!second_q && stat_mode_q == rwsz_pkg::MODE_STD) begin
						go_second = 1'b1;
						cmd.start = 1'b1;
						cmd.count = rwsz_pkg::CNT_W'(K_STD);
						it_num    = it_res;
						it_den    = NW'(w);
					end else if (!second_q && stat_mode_q == rwsz_pkg::MODE_Z) begin
						go_second = 1'b1;
						cmd.start = 1'b1;
						cmd.op    = rwsz_pkg::OP_SQRT;
						cmd.count = rwsz_pkg::CNT_W'(M_Z);
						it_num    = it_res;
					end else begin
						set_res = 1'b1;
						state_d = ST_DONE;
						set_mag = it_res;
						if (stat_mode_q == rwsz_pkg::MODE_MEAN) begin
							set_neg = sum_q[SUM_W-1];
						end else if (stat_mode_q == rwsz_pkg::MODE_Z) begin
							set_neg = n_q[N_W-1];
						end
					end
				end
			end
			ST_DONE: begin
				if (!has_q) begin
					state_d = ST_IDLE;
				end else if (!out_valid_q || out_ch.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	rwsz_iter #(
		.NW (NW)
	) u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.num    (it_num),
		.den    (it_den),
		.stat   (ist),
		.res    (it_res)
	);

	// saturate to the output range
	always_comb begin
		mag_ext = BIGW'(mag_q);
		if (neg_q) begin
			if (mag_ext > BIGW'(rwsz_pkg::VAL_MIN)) begin
				val_sat = rwsz_pkg::VAL_MIN;
			end else begin
				val_sat = rwsz_pkg::VAL_W'(0) - mag_ext[rwsz_pkg::VAL_W-1:0];
			end
		end else if (mag_ext > BIGW'(rwsz_pkg::VAL_MAX)) begin
			val_sat = rwsz_pkg::VAL_MAX;
		end else begin
			val_sat = mag_ext[rwsz_pkg::VAL_W-1:0];
		end
	end

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.value       = out_value_q;
	assign out_ch.short_error = out_err_q;

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			window_len_q <= rwsz_pkg::WLEN_W'(1);
			stat_mode_q  <= rwsz_pkg::MODE_SUM;
			slot_q       <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			sumsq_q      <= '0;
			full_q       <= 1'b0;
			second_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr) begin
				if (cfg_idx == rwsz_pkg::REG_WINDOW_LEN) begin
					window_len_q <= pwdata[rwsz_pkg::WLEN_W-1:0];
					slot_q       <= '0;
					fill_q       <= '0;
					sum_q        <= '0;
					sumsq_q      <= '0;
				end else begin
					stat_mode_q <= pwdata[rwsz_pkg::MODE_W-1:0];
				end
			end

			unique case (state_q)
				ST_RD: begin
					full_q <= full_e;
					fill_q <= full_e ? w : fill_e + 1'b1;
					slot_q <= slot_nx;
					if (first_q) begin
						sum_q   <= '0;
						sumsq_q <= '0;
					end
				end
				ST_UPD: begin
					// add the newest sample and, once the window is full, drop the oldest
					sum_q <= sum_q - (full_q ? SUM_W'(old_s) : '0) + SUM_W'(x_q);
				end
				ST_SQR: begin
					sumsq_q <= sumsq_q - (full_q ? SQ_W'(oldsq_q) : '0) + SQ_W'(xsq_q);
				end
				ST_OP1: second_q <= 1'b0;
				ST_RUN: if (go_second) second_q <= 1'b1;
				ST_DONE: begin
					if (state_d == ST_IDLE && last_q) begin
						slot_q  <= '0;
						fill_q  <= '0;
						sum_q   <= '0;
						sumsq_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			x_q     <= in_ch.sample;
			first_q <= in_ch.first;
			last_q  <= in_ch.last;
		end
		if (state_q == ST_RD) begin
			xsq_q <= xsq_full;
		end
		if (state_q == ST_UPD) begin
			oldsq_q <= oldsq_full;
		end
		if (state_q == ST_MUL) begin
			wsq_q <= D_W'(w) * D_W'(sumsq_q);
			ssq_q <= D_W'(sum_mag) * D_W'(sum_mag);
			w2_q  <= W2_W'(w) * W2_W'(w);
			wx_q  <= w_s * x_s;
		end
		if (state_q == ST_DIFF) begin
			d_q <= (wsq_q > ssq_q) ? wsq_q - ssq_q : '0;
			n_q <= wx_q - N_W'(sum_q);
		end
		if (state_q == ST_NSQ) begin
			nsq_q <= NSQ_W'(n_mag) * NSQ_W'(n_mag);
		end
		if (set_res) begin
			mag_q <= set_mag;
			neg_q <= set_neg;
			err_q <= set_err;
			has_q <= set_has;
		end
		if (load_out) begin
			out_value_q <= err_q ? '0 : val_sat;
			out_err_q   <= err_q;
		end
	end

endmodule
